// ----- sv/npcv_pkg.sv -----
// ----------------------------------------------------------------------------
// npcv_pkg
// Shared types, constants and helpers of the nine-patch axis edge generator.
// ----------------------------------------------------------------------------
package npcv_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SCALE_SHIFT = FRAC_BITS - 8;
    localparam int DIV_W       = 32 + FRAC_BITS;
    localparam int DVSR_W      = 32;
    localparam int CNT_W       = $clog2(DIV_W + 1);
    localparam int LERP_W      = FRAC_BITS + 1;
    localparam int PROD_W      = 33 + LERP_W + 1;

    localparam logic [2:0] CFG_CLIP_X_LOW     = 3'd0;
    localparam logic [2:0] CFG_CLIP_X_HIGH    = 3'd1;
    localparam logic [2:0] CFG_CLIP_Y_LOW     = 3'd2;
    localparam logic [2:0] CFG_CLIP_Y_HIGH    = 3'd3;
    localparam logic [2:0] CFG_WINDOW_WIDTH   = 3'd4;
    localparam logic [2:0] CFG_WINDOW_HEIGHT  = 3'd5;
    localparam logic [2:0] CFG_UI_SCALE       = 3'd6;

    localparam logic KIND_HORIZ = 1'b0;
    localparam logic KIND_VERT  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] rect_pos;
        logic [30:0]        rect_size;
        logic [11:0]        margin_lo;
        logic [11:0]        margin_hi;
        logic [11:0]        pad_lo;
        logic [11:0]        pad_hi;
        logic signed [31:0] tex_lo;
        logic signed [31:0] tex_hi;
        logic [14:0]        tex_dim;
        logic               tiled;
        logic signed [31:0] view_offset;
    } item_t;

    typedef struct packed {
        logic [1:0]         edge_index;
        logic signed [31:0] ndc_pos;
        logic signed [31:0] tex_coord;
        logic               last;
    } result_t;

    typedef struct packed {
        logic signed [31:0] clip_x_low;
        logic signed [31:0] clip_x_high;
        logic signed [31:0] clip_y_low;
        logic signed [31:0] clip_y_high;
        logic [14:0]        window_width;
        logic [14:0]        window_height;
        logic [15:0]        ui_scale;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] base;
        logic signed [31:0] size;
        logic signed [31:0] plo_s;
        logic signed [31:0] phi_s;
        logic [11:0]        plo_raw;
        logic [11:0]        phi_raw;
        logic signed [31:0] tlo;
        logic signed [31:0] thi;
        logic [14:0]        dim;
        logic               tiled;
        logic signed [31:0] clip_lo;
        logic signed [31:0] clip_hi;
        logic [14:0]        win;
    } job_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- sv/nine_patch_axis_clip_vertex_gen_top.sv -----
// ----------------------------------------------------------------------------
// nine_patch_axis_clip_vertex_gen_top
// Nine-patch axis edge generator with clip against the configured bounds.
// The back end works one request at a time: n_pre divides (insets, tiling), then
//   n_clip clip interpolations, then one NDC divide per edge; n_pre is 0, 2 or 3
//   divides and n_clip is 0 to 2 clip interpolations.
// Each of the four results of a request follows its own NDC divide.
// Front end and a two-deep queue take new requests while the back end works.
// Results appear as single-cycle strobes; the receiver cannot stall.
// Reset clears all control state and loads the register defaults.
// ----------------------------------------------------------------------------
module nine_patch_axis_clip_vertex_gen_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  npcv_pkg::item_t   item,
    output logic              res_valid,
    output npcv_pkg::result_t res,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import npcv_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_full, q_empty, push, pop;
    job_t push_job, head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLIP_X_LOW:    cfg_next.clip_x_low    = cfg_data;
                CFG_CLIP_X_HIGH:   cfg_next.clip_x_high   = cfg_data;
                CFG_CLIP_Y_LOW:    cfg_next.clip_y_low    = cfg_data;
                CFG_CLIP_Y_HIGH:   cfg_next.clip_y_high   = cfg_data;
                CFG_WINDOW_WIDTH:  cfg_next.window_width  = cfg_data[14:0];
                CFG_WINDOW_HEIGHT: cfg_next.window_height = cfg_data[14:0];
                CFG_UI_SCALE:      cfg_next.ui_scale      = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_x_low    <= 32'sh80000000;
            cfg_reg.clip_x_high   <= 32'sh7fffffff;
            cfg_reg.clip_y_low    <= 32'sh80000000;
            cfg_reg.clip_y_high   <= 32'sh7fffffff;
            cfg_reg.window_width  <= 15'd1920;
            cfg_reg.window_height <= 15'd1080;
            cfg_reg.ui_scale      <= 16'd256;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    npcv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .push   (push),
        .job    (push_job)
    );

    npcv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    npcv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// ----- sv/npcv_div.sv -----
// ----------------------------------------------------------------------------
// npcv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module npcv_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [npcv_pkg::DIV_W-1:0]  dividend,
    input  logic [npcv_pkg::DVSR_W-1:0] divisor,
    output logic                       done,
    output logic [npcv_pkg::DIV_W-1:0]  quot,
    output logic                       rem_nz
);
    import npcv_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quot_reg, quot_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;
    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        trial     = {rem_reg, quot_reg[DIV_W-1]};
        diff      = trial - {1'b0, dvsr_reg};
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            quot_next = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
        end
        else if (run_reg)
        begin
            if (!diff[DVSR_W])
            begin
                rem_next  = diff[DVSR_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DVSR_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done   = done_reg;
    assign quot   = quot_reg;
    assign rem_nz = |rem_reg;

endmodule

// ----- sv/npcv_queue.sv -----
// ----------------------------------------------------------------------------
// npcv_queue
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
module npcv_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  npcv_pkg::job_t push_job,
    input  logic           pop,
    output npcv_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import npcv_pkg::*;

    job_t       slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = ~wr_reg;
        end
        if (pop)
        begin
            rd_next = ~rd_reg;
        end
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    assign head  = slot_reg[rd_reg];
    assign full  = cnt_reg[1];
    assign empty = (cnt_reg == 2'd0);

endmodule

// ----- sv/npcv_front.sv -----
// ----------------------------------------------------------------------------
// npcv_front
// Accept requests, scale margins and padding, form the widened rectangle.
// ----------------------------------------------------------------------------
module npcv_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  npcv_pkg::item_t item,
    input  npcv_pkg::cfg_t  cfg,
    input  logic            q_full,
    output logic            push,
    output npcv_pkg::job_t  job
);
    import npcv_pkg::*;

    function automatic logic signed [31:0] scale_px(input logic [11:0] px,
                                                    input logic [15:0] sc);
        logic [27:0] prod;
        logic [63:0] w;
        prod = 28'(px) * 28'(sc);
        w    = 64'(prod) << SCALE_SHIFT;
        return sat32(signed'(w));
    endfunction

    logic               s1_valid_reg, s1_valid_next;
    item_t              s1_item_reg;
    logic signed [31:0] mlo_reg, mhi_reg, plo_reg, phi_reg;
    logic               accept;
    logic signed [31:0] base0;

    assign busy   = s1_valid_reg && q_full;
    assign accept = start && !busy;
    assign push   = s1_valid_reg && !q_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
            mlo_reg     <= scale_px(item.margin_lo, cfg.ui_scale);
            mhi_reg     <= scale_px(item.margin_hi, cfg.ui_scale);
            plo_reg     <= scale_px(item.pad_lo, cfg.ui_scale);
            phi_reg     <= scale_px(item.pad_hi, cfg.ui_scale);
        end
    end

    always_comb
    begin
        base0       = sat32(64'(s1_item_reg.rect_pos) - 64'(mlo_reg));
        job.kind    = s1_item_reg.kind;
        job.base    = sat32(64'(base0) + 64'(s1_item_reg.view_offset));
        job.size    = sat32(64'(s1_item_reg.rect_size) + 64'(mlo_reg) + 64'(mhi_reg));
        job.plo_s   = plo_reg;
        job.phi_s   = phi_reg;
        job.plo_raw = s1_item_reg.pad_lo;
        job.phi_raw = s1_item_reg.pad_hi;
        job.tlo     = s1_item_reg.tex_lo;
        job.thi     = s1_item_reg.tex_hi;
        job.dim     = s1_item_reg.tex_dim;
        job.tiled   = s1_item_reg.tiled;
        if (s1_item_reg.kind == KIND_VERT)
        begin
            job.clip_lo = cfg.clip_y_low;
            job.clip_hi = cfg.clip_y_high;
            job.win     = (cfg.window_height == '0) ? 15'd1 : cfg.window_height;
        end
        else
        begin
            job.clip_lo = cfg.clip_x_low;
            job.clip_hi = cfg.clip_x_high;
            job.win     = (cfg.window_width == '0) ? 15'd1 : cfg.window_width;
        end
    end

endmodule

// ----- sv/npcv_back.sv -----
// ----------------------------------------------------------------------------
// npcv_back
// Sequence insets, tiling, clipping, merge and NDC conversion over one shared divider.
// ----------------------------------------------------------------------------
module npcv_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  npcv_pkg::job_t    head,
    output logic              pop,
    output logic              res_valid,
    output npcv_pkg::result_t res
);
    import npcv_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_ILO   = 11'b00000000010,
        ST_IHI   = 11'b00000000100,
        ST_TILE  = 11'b00000001000,
        ST_BUILD = 11'b00000010000,
        ST_CLIP  = 11'b00000100000,
        ST_LERP  = 11'b00001000000,
        ST_MUL   = 11'b00010000000,
        ST_APPLY = 11'b00100000000,
        ST_MERGE = 11'b01000000000,
        ST_NDC   = 11'b10000000000
    } state_t;

    localparam logic [1:0] SEG_OUTER_LO = 2'd0;
    localparam logic [1:0] SEG_MIDDLE   = 2'd1;
    localparam logic [1:0] SEG_OUTER_HI = 2'd2;
    localparam logic       SIDE_LOW     = 1'b0;
    localparam logic       SIDE_HIGH    = 1'b1;
    localparam logic [1:0] LAST_EDGE    = 2'd3;
    localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;

    function automatic logic signed [31:0] pick4(input logic signed [31:0] v0,
                                                 input logic signed [31:0] v1,
                                                 input logic signed [31:0] v2,
                                                 input logic signed [31:0] v3,
                                                 input logic [1:0] s);
        logic signed [31:0] r;
        unique case (s)
            2'd0:    r = v0;
            2'd1:    r = v1;
            2'd2:    r = v2;
            default: r = v3;
        endcase
        return r;
    endfunction

    state_t               state_reg, state_next;
    job_t                 job_reg, job_next;
    logic signed [31:0]   p_reg [4];
    logic signed [31:0]   p_next [4];
    logic signed [31:0]   t_reg [4];
    logic signed [31:0]   t_next [4];
    logic signed [31:0]   ilo_reg, ilo_next, ihi_reg, ihi_next, thi_reg, thi_next;
    logic                 side_reg, side_next;
    logic [1:0]           seg_reg, seg_next;
    logic [1:0]           k_reg, k_next;
    logic [LERP_W-1:0]    l_reg, l_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                 strobe_reg, strobe_next;
    result_t              res_reg, res_next;

    logic                 div_start, div_done, div_rnz;
    logic [DIV_W-1:0]     div_dvd, div_quot;
    logic [DVSR_W-1:0]    div_dvsr;

    logic signed [31:0]   bound, pa, pb, ta, tb, n, pk, ilo_e, ihi_e, mid;
    logic [1:0]           seg_c, seg_u;
    logic signed [32:0]   span, tdiff;
    logic signed [33:0]   pn, pmag;
    logic [1:0]           k_sel;
    logic signed [63:0]   qw, fq, v;
    logic signed [32:0]   psum;

    npcv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvsr),
        .done     (div_done),
        .quot     (div_quot),
        .rem_nz   (div_rnz)
    );

    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        p_next      = p_reg;
        t_next      = t_reg;
        ilo_next    = ilo_reg;
        ihi_next    = ihi_reg;
        thi_next    = thi_reg;
        side_next   = side_reg;
        seg_next    = seg_reg;
        k_next      = k_reg;
        l_next      = l_reg;
        prod_next   = prod_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        pop         = 1'b0;
        div_start   = 1'b0;
        div_dvd     = '0;
        div_dvsr    = '0;

        bound = (side_reg == SIDE_HIGH) ? job_reg.clip_hi : job_reg.clip_lo;
        if (bound < p_reg[1])
        begin
            seg_c = SEG_OUTER_LO;
        end
        else if (bound < p_reg[2])
        begin
            seg_c = SEG_MIDDLE;
        end
        else
        begin
            seg_c = SEG_OUTER_HI;
        end
        seg_u = (state_reg == ST_CLIP) ? seg_c : seg_reg;
        pa    = pick4(p_reg[0], p_reg[1], p_reg[2], p_reg[3], seg_u);
        pb    = pick4(p_reg[0], p_reg[1], p_reg[2], p_reg[3], seg_u + 2'd1);
        ta    = pick4(t_reg[0], t_reg[1], t_reg[2], t_reg[3], seg_u);
        tb    = pick4(t_reg[0], t_reg[1], t_reg[2], t_reg[3], seg_u + 2'd1);
        span  = $signed({bound[31], bound}) - $signed({pa[31], pa});
        tdiff = $signed({tb[31], tb}) - $signed({ta[31], ta});
        n     = sat32(64'(ta) + 64'(prod_reg >>> FRAC_BITS));

        k_sel = (state_reg == ST_MERGE) ? 2'd0
              : (div_done ? k_reg + 2'd1 : k_reg);
        pk    = pick4(p_reg[0], p_reg[1], p_reg[2], p_reg[3], k_sel);
        pn    = $signed({pk[31], pk, 1'b0});
        pmag  = pn[33] ? -pn : pn;
        psum  = $signed({p_reg[1][31], p_reg[1]}) + $signed({p_reg[2][31], p_reg[2]});
        mid   = psum[32:1];

        ilo_e = (thi_reg < job_reg.tlo) ? -ilo_reg : ilo_reg;
        ihi_e = (thi_reg < job_reg.tlo) ? -ihi_reg : ihi_reg;

        qw = signed'(64'(div_quot));
        fq = (pick4(p_reg[0], p_reg[1], p_reg[2], p_reg[3], k_reg) < 0)
           ? (-qw - 64'(div_rnz)) : qw;
        v  = (job_reg.kind == KIND_VERT) ? -(fq - ONE_FX) : (fq - ONE_FX);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    job_next  = head;
                    ilo_next  = '0;
                    ihi_next  = '0;
                    thi_next  = head.thi;
                    side_next = SIDE_LOW;
                    if (head.dim != '0)
                    begin
                        div_start  = 1'b1;
                        div_dvd    = DIV_W'(head.plo_raw) << FRAC_BITS;
                        div_dvsr   = DVSR_W'(head.dim);
                        state_next = ST_ILO;
                    end
                    else
                    begin
                        state_next = ST_BUILD;
                    end
                end
            end
            ST_ILO:
            begin
                if (div_done)
                begin
                    ilo_next   = sat32(qw);
                    div_start  = 1'b1;
                    div_dvd    = DIV_W'(job_reg.phi_raw) << FRAC_BITS;
                    div_dvsr   = DVSR_W'(job_reg.dim);
                    state_next = ST_IHI;
                end
            end
            ST_IHI:
            begin
                if (div_done)
                begin
                    ihi_next = sat32(qw);
                    if (job_reg.tiled)
                    begin
                        div_start  = 1'b1;
                        div_dvd    = DIV_W'(unsigned'(job_reg.size));
                        div_dvsr   = DVSR_W'(job_reg.dim);
                        state_next = ST_TILE;
                    end
                    else
                    begin
                        state_next = ST_BUILD;
                    end
                end
            end
            ST_TILE:
            begin
                if (div_done)
                begin
                    thi_next   = sat32(qw);
                    state_next = ST_BUILD;
                end
            end
            ST_BUILD:
            begin
                p_next[0]  = job_reg.base;
                p_next[1]  = sat32(64'(job_reg.base) + 64'(job_reg.plo_s));
                p_next[2]  = sat32(64'(job_reg.base) + 64'(job_reg.size)
                                   - 64'(job_reg.phi_s));
                p_next[3]  = sat32(64'(job_reg.base) + 64'(job_reg.size));
                t_next[0]  = job_reg.tlo;
                t_next[1]  = sat32(64'(job_reg.tlo) + 64'(ilo_e));
                t_next[2]  = sat32(64'(thi_reg) - 64'(ihi_e));
                t_next[3]  = thi_reg;
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                if (!(bound < p_reg[3] && bound > p_reg[0]))
                begin
                    if (side_reg == SIDE_LOW)
                    begin
                        side_next = SIDE_HIGH;
                    end
                    else
                    begin
                        state_next = ST_MERGE;
                    end
                end
                else
                begin
                    seg_next   = seg_c;
                    div_start  = 1'b1;
                    div_dvd    = DIV_W'(span[31:0]) << FRAC_BITS;
                    div_dvsr   = 32'(pb - pa);
                    state_next = ST_LERP;
                end
            end
            ST_LERP:
            begin
                if (div_done)
                begin
                    l_next     = div_quot[LERP_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(tdiff) * PROD_W'($signed({1'b0, l_reg}));
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (side_reg == SIDE_LOW)
                begin
                    p_next[0] = bound;
                    t_next[0] = n;
                    if (seg_reg != SEG_OUTER_LO)
                    begin
                        p_next[1] = bound;
                        t_next[1] = n;
                    end
                    if (seg_reg == SEG_OUTER_HI)
                    begin
                        p_next[2] = bound;
                        t_next[2] = n;
                    end
                    side_next  = SIDE_HIGH;
                    state_next = ST_CLIP;
                end
                else
                begin
                    p_next[3] = bound;
                    t_next[3] = n;
                    if (seg_reg != SEG_OUTER_HI)
                    begin
                        p_next[2] = bound;
                        t_next[2] = n;
                    end
                    if (seg_reg == SEG_OUTER_LO)
                    begin
                        p_next[1] = bound;
                        t_next[1] = n;
                    end
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (p_reg[1] > p_reg[2])
                begin
                    p_next[1] = mid;
                    p_next[2] = mid;
                end
                k_next     = 2'd0;
                div_start  = 1'b1;
                div_dvd    = DIV_W'(unsigned'(pmag));
                div_dvsr   = DVSR_W'(job_reg.win);
                state_next = ST_NDC;
            end
            ST_NDC:
            begin
                if (div_done)
                begin
                    strobe_next         = 1'b1;
                    res_next.edge_index = k_reg;
                    res_next.ndc_pos    = sat32(v);
                    res_next.tex_coord  = pick4(t_reg[0], t_reg[1], t_reg[2], t_reg[3],
                                                k_reg);
                    res_next.last       = (k_reg == LAST_EDGE);
                    if (k_reg == LAST_EDGE)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next    = k_reg + 2'd1;
                        div_start = 1'b1;
                        div_dvd   = DIV_W'(unsigned'(pmag));
                        div_dvsr  = DVSR_W'(job_reg.win);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            side_reg   <= SIDE_LOW;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            side_reg   <= side_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        p_reg    <= p_next;
        t_reg    <= t_next;
        ilo_reg  <= ilo_next;
        ihi_reg  <= ihi_next;
        thi_reg  <= thi_next;
        seg_reg  <= seg_next;
        l_reg    <= l_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign res_valid = strobe_reg;
    assign res       = res_reg;

endmodule

// ----- sv/npcv_checker.sv -----
// ----------------------------------------------------------------------------
// npcv_checker
// Port-level checks of the edge generator, bound to the top level.
// ----------------------------------------------------------------------------
module npcv_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              busy,
    input logic              res_valid,
    input npcv_pkg::result_t res
);
    import npcv_pkg::*;

    a_last_on_edge3: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.last == (res.edge_index == 2'd3)))
        else $error("last flag does not match edge index");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> !res_valid)
        else $error("two results in consecutive cycles");

    a_edge_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.last |=> !res_valid || res.edge_index != 2'd0)
        else $error("edge sequence restarted early");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !busy && !res_valid)
        else $error("busy or result during reset");

endmodule

bind nine_patch_axis_clip_vertex_gen_top npcv_checker u_npcv_checker (.*);

// ----- test/tb_nine_patch_axis_clip_vertex_gen_top.sv -----
// ----------------------------------------------------------------------------
// tb_nine_patch_axis_clip_vertex_gen_top
// Self-checking bench for the nine-patch axis edge generator. Directed
// requests cover field extremes, texture flip, tiling, clipping in every
// segment, crossed inner edges, and zero window and scale. Random requests
// follow under several register settings and idle patterns. Every edge
// result is compared field by field against an in-bench edge predictor.
// ----------------------------------------------------------------------------
module tb_nine_patch_axis_clip_vertex_gen_top;
    timeunit 1ns;
    timeprecision 1ps;
    import npcv_pkg::*;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 600;
    localparam longint ONE = 64'sd1 <<< FRAC_BITS;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    res_valid;
    result_t res;
    logic    cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    longint  clip_bound [4];
    longint  win_size [2];
    longint  scale_q88;

    result_t edge_queue[$];
    int      mismatches;
    int      results_seen;
    int      requests_sent;
    int      idle_cycles;
    int      send_idle_pct;
    bit      timed_out;

    nine_patch_axis_clip_vertex_gen_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .res_valid (res_valid),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint interp_tex(input longint ta, input longint tb, input longint x,
                                          input longint pa, input longint pb);
        longint l;
        l = ((x - pa) * ONE) / (pb - pa);
        return clamp32(ta + floor_div((tb - ta) * l, ONE));
    endfunction

    function automatic longint scale_px(input longint px);
        return clamp32((px * scale_q88) * (64'sd1 <<< (FRAC_BITS - 8)));
    endfunction

    task automatic clip_from_low(inout longint p[4], inout longint t[4], input longint b);
        longint n;
        if (!(b < p[3] && b > p[0]))
        begin
            return;
        end
        if (b < p[1])
        begin
            n = interp_tex(t[0], t[1], b, p[0], p[1]);
            p[0] = b; t[0] = n;
        end
        else if (b < p[2])
        begin
            n = interp_tex(t[1], t[2], b, p[1], p[2]);
            p[0] = b; p[1] = b; t[0] = n; t[1] = n;
        end
        else
        begin
            n = interp_tex(t[2], t[3], b, p[2], p[3]);
            p[0] = b; p[1] = b; p[2] = b; t[0] = n; t[1] = n; t[2] = n;
        end
    endtask

    task automatic clip_from_high(inout longint p[4], inout longint t[4], input longint b);
        longint n;
        if (!(b < p[3] && b > p[0]))
        begin
            return;
        end
        if (b < p[1])
        begin
            n = interp_tex(t[0], t[1], b, p[0], p[1]);
            p[1] = b; p[2] = b; p[3] = b; t[1] = n; t[2] = n; t[3] = n;
        end
        else if (b < p[2])
        begin
            n = interp_tex(t[1], t[2], b, p[1], p[2]);
            p[2] = b; p[3] = b; t[2] = n; t[3] = n;
        end
        else
        begin
            n = interp_tex(t[2], t[3], b, p[2], p[3]);
            p[3] = b; t[3] = n;
        end
    endtask

    task automatic predict_edges(input item_t it);
        longint  mlo, mhi, plo, phi, tlo, thi, dim, ilo, ihi, base, sz, win, v;
        longint  p[4];
        longint  t[4];
        result_t r;
        int      ax;
        ax  = (it.kind == KIND_VERT) ? 1 : 0;
        mlo = scale_px(longint'(it.margin_lo));
        mhi = scale_px(longint'(it.margin_hi));
        plo = scale_px(longint'(it.pad_lo));
        phi = scale_px(longint'(it.pad_hi));
        tlo = longint'(it.tex_lo);
        thi = longint'(it.tex_hi);
        dim = longint'(it.tex_dim);
        ilo = 0;
        ihi = 0;
        base = clamp32(longint'(it.rect_pos) - mlo);
        sz   = clamp32(longint'(it.rect_size) + mlo + mhi);
        if (dim != 0)
        begin
            ilo = clamp32((longint'(it.pad_lo) * ONE) / dim);
            ihi = clamp32((longint'(it.pad_hi) * ONE) / dim);
            if (it.tiled)
            begin
                thi = sz / dim;
            end
        end
        if (thi < tlo)
        begin
            ilo = -ilo;
            ihi = -ihi;
        end
        base = clamp32(base + longint'(it.view_offset));
        p[0] = base;
        p[1] = clamp32(base + plo);
        p[2] = clamp32(base + sz - phi);
        p[3] = clamp32(base + sz);
        t[0] = tlo;
        t[1] = clamp32(tlo + ilo);
        t[2] = clamp32(thi - ihi);
        t[3] = thi;
        clip_from_low(p, t, clip_bound[ax * 2]);
        clip_from_high(p, t, clip_bound[ax * 2 + 1]);
        if (p[1] > p[2])
        begin
            p[1] = floor_div(p[1] + p[2], 2);
            p[2] = p[1];
        end
        win = (win_size[ax] == 0) ? 1 : win_size[ax];
        for (int k = 0; k < 4; k++)
        begin
            v = floor_div(2 * p[k], win) - ONE;
            if (ax == 1)
            begin
                v = -v;
            end
            r.edge_index = 2'(k);
            r.ndc_pos    = 32'(clamp32(v));
            r.tex_coord  = 32'(t[k]);
            r.last       = (k == 3);
            edge_queue.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && res_valid)
        begin
            results_seen++;
            idle_cycles = 0;
            if (edge_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected edge result %p", res);
                end
            end
            else
            begin
                exp_r = edge_queue.pop_front();
                if (res !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("edge mismatch: expected %p, got %p", exp_r, res);
                    end
                end
            end
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_CLIP_X_LOW:    clip_bound[0] = longint'($signed(val));
            CFG_CLIP_X_HIGH:   clip_bound[1] = longint'($signed(val));
            CFG_CLIP_Y_LOW:    clip_bound[2] = longint'($signed(val));
            CFG_CLIP_Y_HIGH:   clip_bound[3] = longint'($signed(val));
            CFG_WINDOW_WIDTH:  win_size[0]   = longint'(val[14:0]);
            CFG_WINDOW_HEIGHT: win_size[1]   = longint'(val[14:0]);
            default:           scale_q88     = longint'(val[15:0]);
        endcase
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (edge_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // drive one request at a falling edge, hold until accepted
    task automatic send_request(input item_t it);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        idle_cycles = 0;
        predict_edges(it);
        requests_sent++;
        @(negedge clk);
    endtask

    function automatic item_t random_item();
        item_t it;
        int    sel;
        it = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        sel = $urandom_range(9, 0);
        if (sel < 7)
        begin
            it.rect_pos    = $signed($urandom_range(400, 0) << FRAC_BITS) - (50 <<< FRAC_BITS);
            it.rect_size   = 31'($urandom_range(600, 0)) << FRAC_BITS;
            it.margin_lo   = 12'($urandom_range(40, 0));
            it.margin_hi   = 12'($urandom_range(40, 0));
            it.pad_lo      = 12'($urandom_range(200, 0));
            it.pad_hi      = 12'($urandom_range(200, 0));
            it.tex_lo      = $signed(32'($urandom_range(65536, 0)));
            it.tex_hi      = $signed(32'($urandom_range(65536, 0)));
            it.tex_dim     = 15'($urandom_range(256, 0));
            it.view_offset = $signed(32'($urandom_range(20 << FRAC_BITS, 0)))
                             - (10 <<< FRAC_BITS);
        end
        else if (sel < 9)
        begin
            it.tex_dim = 15'($urandom_range(16384, 0));
        end
        return it;
    endfunction

    function automatic item_t mk_item(input logic k, input int pos, input int sz,
                                      input int m_lo, input int m_hi, input int p_lo,
                                      input int p_hi, input int t_lo, input int t_hi,
                                      input int dim, input logic tl, input int off);
        item_t it;
        it.kind = k; it.rect_pos = pos; it.rect_size = 31'(sz);
        it.margin_lo = 12'(m_lo); it.margin_hi = 12'(m_hi);
        it.pad_lo = 12'(p_lo); it.pad_hi = 12'(p_hi);
        it.tex_lo = t_lo; it.tex_hi = t_hi; it.tex_dim = 15'(dim);
        it.tiled = tl; it.view_offset = off;
        return it;
    endfunction

    initial
    begin
        item_t  dir_table[$];
        int     pass_count;
        clk_init();
        // directed: extremes, flip, tiling, clip segments, crossed edges
        dir_table.push_back(mk_item(KIND_HORIZ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_item(KIND_VERT, 100 << 16, 200 << 16, 10, 10, 20, 20, 0, 65536,
                                    64, 0, 0));
        dir_table.push_back(mk_item(KIND_HORIZ, 32'h7fffffff, 31'h7fffffff, 4095, 4095, 4095,
                                    4095, 32'h7fffffff, 32'h80000000, 16384, 1, 32'h7fffffff));
        dir_table.push_back(mk_item(KIND_VERT, 32'h80000000, 0, 4095, 0, 0, 4095,
                                    32'h80000000, 32'h7fffffff, 1, 0, 32'h80000000));
        dir_table.push_back(mk_item(KIND_HORIZ, 0, 100 << 16, 0, 0, 10, 10, 65536, 0, 16, 0, 0));
        dir_table.push_back(mk_item(KIND_HORIZ, 0, 100 << 16, 5, 5, 10, 10, 0, 65536, 16, 1, 0));
        dir_table.push_back(mk_item(KIND_VERT, 0, 100 << 16, 5, 5, 10, 10, 0, 65536, 0, 1, 0));
        dir_table.push_back(mk_item(KIND_HORIZ, 0, 20 << 16, 0, 0, 30, 30, 0, 65536, 32, 0, 0));
        dir_table.push_back(mk_item(KIND_VERT, 7, 3, 0, 0, 1, 1, 1, 2, 3, 0, -5));
        dir_table.push_back(mk_item(KIND_HORIZ, -(300 << 16), 900 << 16, 10, 10, 50, 50,
                                    0, 65536, 128, 0, 0));
        dir_table.push_back(mk_item(KIND_VERT, -(300 << 16), 900 << 16, 10, 10, 50, 50,
                                    65536, 0, 128, 1, 1 << 16));
        send_idle_pct = 0;
        foreach (dir_table[i])
        begin
            send_request(dir_table[i]);
        end
        wait_drained();
        // clip inside each segment, tiny window and zero scale
        write_reg(CFG_CLIP_X_LOW, 32'(-(200 <<< 16)));
        write_reg(CFG_CLIP_X_HIGH, 32'(500 << 16));
        write_reg(CFG_CLIP_Y_LOW, 32'(-(290 <<< 16)));
        write_reg(CFG_CLIP_Y_HIGH, 32'(590 << 16));
        write_reg(CFG_WINDOW_WIDTH, 32'd0);
        write_reg(CFG_WINDOW_HEIGHT, 32'd16384);
        write_reg(CFG_UI_SCALE, 32'd0);
        foreach (dir_table[i])
        begin
            send_request(dir_table[i]);
        end
        wait_drained();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 52 : 0;
            write_reg(CFG_CLIP_X_LOW, (ph == 2) ? 32'h80000000 : 32'($urandom_range(80, 0) << 16));
            write_reg(CFG_CLIP_X_HIGH, (ph == 2) ? 32'h7fffffff :
                                       32'($urandom_range(700, 200) << 16));
            write_reg(CFG_CLIP_Y_LOW, (ph == 1) ? $urandom : 32'($urandom_range(80, 0) << 16));
            write_reg(CFG_CLIP_Y_HIGH, (ph == 1) ? $urandom : 32'($urandom_range(700, 200) << 16));
            write_reg(CFG_WINDOW_WIDTH, (ph == 2) ? 32'd1 : 32'($urandom_range(16384, 1)));
            write_reg(CFG_WINDOW_HEIGHT, (ph == 0) ? 32'd16384 : 32'($urandom_range(16384, 1)));
            write_reg(CFG_UI_SCALE, (ph == 1) ? 32'd65535 : 32'($urandom_range(1024, 1)));
            for (int n = 0; n < 80; n++)
            begin
                send_request(random_item());
                if (n == 40)
                begin
                    // hold requests until the pipeline has emptied
                    start <= 1'b0;
                    while (edge_queue.size() != 0)
                    begin
                        @(negedge clk);
                    end
                end
            end
            wait_drained();
        end
        pass_count = requests_sent;
        $display("covered %0d requests and %0d edge results over five register settings",
                 pass_count, results_seen);
        if (mismatches == 0 && edge_queue.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d mismatches, %0d edges outstanding", mismatches, edge_queue.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    task automatic clk_init();
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_CLIP_X_LOW;
        cfg_data  = '0;
        mismatches    = 0;
        results_seen  = 0;
        requests_sent = 0;
        idle_cycles   = 0;
        timed_out     = 1'b0;
        clip_bound[0] = -64'sd2147483648;
        clip_bound[1] = 64'sd2147483647;
        clip_bound[2] = -64'sd2147483648;
        clip_bound[3] = 64'sd2147483647;
        win_size[0]   = 1920;
        win_size[1]   = 1080;
        scale_q88     = 256;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
    endtask

endmodule

// ----- filelist.f -----
sv/npcv_pkg.sv
sv/npcv_div.sv
sv/npcv_queue.sv
sv/npcv_front.sv
sv/npcv_back.sv
sv/nine_patch_axis_clip_vertex_gen_top.sv
sv/npcv_checker.sv
test/tb_nine_patch_axis_clip_vertex_gen_top.sv
